// ----- rtl/core/utd_pkg.sv -----
// Package for the UTF-8 text detector.
// Holds verdict codes, byte constants and the byte class record; no dependencies.
package utd_pkg;

    typedef logic [2:0] code_t;
    typedef logic [2:0] count_t;

    localparam code_t FAIL_NONE     = 3'd0;
    localparam code_t VERDICT_UTF8  = 3'd0;
    localparam code_t VERDICT_ASCII = 3'd1;
    localparam code_t FAIL_CTRL     = 3'd2;
    localparam code_t FAIL_LEAD     = 3'd3;
    localparam code_t FAIL_CONT     = 3'd4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BEL   = 8'h07;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ESC   = 8'h1B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    typedef struct packed {
        logic   is_ascii;
        logic   ascii_ok;
        logic   is_cont;
        count_t lead_len;
    } byte_class_t;

endpackage

// ----- rtl/core/utf8_text_detector.sv -----
// Top level of the UTF-8 text detector: input register, string state and result register.
// Depends on utd_pkg and utd_byte_decode.
//
// The block takes one byte per cycle, but a terminating byte waits while the result
// register is not yet read. One verdict comes out per string. A byte goes into an input
// register, is decoded and folded into the string state, and a terminating byte (zero, or
// marked by tlast) loads the result register; the state then starts over for the next
// string. The verdict is 0 for UTF-8 text with at least one complete multibyte sequence,
// 1 for plain 7-bit text, 2 for a bad control character, 3 for a bad lead byte and 4 for a
// bad continuation byte; the first failure of a string is the one reported. A multibyte
// sequence cut short by the end of the string is dropped without failure.
module utf8_text_detector
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
    input  logic       s_axis_tlast,  // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [2:0] verdict, [3] is_utf8, [7:4] zero
);
    import utd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    count_t      pending_reg, pending_next;
    logic        seen_reg, seen_next;
    code_t       fail_reg, fail_next;

    logic        out_valid_reg;
    code_t       verdict_reg, verdict_next;

    byte_class_t cls;
    logic        nonzero;
    logic        term;
    logic        advance;

    utd_byte_decode u_decode
    (
        .data_byte (byte_reg),
        .cls       (cls)
    );

    assign nonzero       = (byte_reg != CHAR_NUL);
    assign term          = ~nonzero | last_reg;
    assign advance       = in_valid_reg & (~term | ~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    always_comb
    begin
        pending_next = pending_reg;
        seen_next    = seen_reg;
        fail_next    = fail_reg;
        if (nonzero && (fail_reg == FAIL_NONE))
        begin
            if (pending_reg != 3'd0)
            begin
                if (!cls.is_cont)
                begin
                    fail_next = FAIL_CONT;
                end
                else
                begin
                    pending_next = pending_reg - 3'd1;
                    if (pending_reg == 3'd1)
                    begin
                        seen_next = 1'b1;
                    end
                end
            end
            else if (cls.is_ascii)
            begin
                if (!cls.ascii_ok)
                begin
                    fail_next = FAIL_CTRL;
                end
            end
            else if (cls.lead_len == 3'd0)
            begin
                fail_next = FAIL_LEAD;
            end
            else
            begin
                pending_next = cls.lead_len;
            end
        end

        if (fail_next != FAIL_NONE)
        begin
            verdict_next = fail_next;
        end
        else if (seen_next)
        begin
            verdict_next = VERDICT_UTF8;
        end
        else
        begin
            verdict_next = VERDICT_ASCII;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pending_reg   <= 3'd0;
            seen_reg      <= 1'b0;
            fail_reg      <= FAIL_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                if (term)
                begin
                    pending_reg <= 3'd0;
                    seen_reg    <= 1'b0;
                    fail_reg    <= FAIL_NONE;
                end
                else
                begin
                    pending_reg <= pending_next;
                    seen_reg    <= seen_next;
                    fail_reg    <= fail_next;
                end
            end
            if (advance && term)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (advance && term)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, (verdict_reg == VERDICT_UTF8), verdict_reg};

endmodule

// ----- rtl/core/utd_byte_decode.sv -----
// Byte classifier for the UTF-8 text detector.
// Purely combinational; depends on utd_pkg.
module utd_byte_decode
(
    input  logic [7:0]           data_byte,
    output utd_pkg::byte_class_t cls
);
    import utd_pkg::*;

    always_comb
    begin
        cls.is_ascii = ~data_byte[7];
        cls.ascii_ok = ((data_byte >= CHAR_SPACE) && (data_byte <= CHAR_TILDE)) ||
                       (data_byte == CHAR_BEL) || (data_byte == CHAR_BS) ||
                       (data_byte == CHAR_HT) || (data_byte == CHAR_LF) ||
                       (data_byte == CHAR_FF) || (data_byte == CHAR_CR) ||
                       (data_byte == CHAR_ESC);
        cls.is_cont  = (data_byte[7:6] == 2'b10);
        if (!data_byte[6])
        begin
            cls.lead_len = 3'd0;
        end
        else if (!data_byte[5])
        begin
            cls.lead_len = 3'd1;
        end
        else if (!data_byte[4])
        begin
            cls.lead_len = 3'd2;
        end
        else if (!data_byte[3])
        begin
            cls.lead_len = 3'd3;
        end
        else if (!data_byte[2])
        begin
            cls.lead_len = 3'd4;
        end
        else if (!data_byte[1])
        begin
            cls.lead_len = 3'd5;
        end
        else
        begin
            cls.lead_len = 3'd0;
        end
    end

endmodule

// ----- rtl/core/utd_checker.sv -----
// Port-level checker for the UTF-8 text detector, bound to the top level.
// Depends on utd_pkg and utf8_text_detector.
module utd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import utd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result dropped or changed while stalled.");

    a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[2:0] == VERDICT_UTF8)))
        else $error("UTF-8 flag disagrees with the verdict.");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == VERDICT_UTF8 ||
                           m_axis_tdata[2:0] == VERDICT_ASCII ||
                           m_axis_tdata[2:0] == FAIL_CTRL ||
                           m_axis_tdata[2:0] == FAIL_LEAD ||
                           m_axis_tdata[2:0] == FAIL_CONT))
        else $error("Verdict code out of range.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'b0000))
        else $error("Result padding bits are not zero.");

    a_ready_after_reset: assert property (@(posedge clk)
        !rst_n |-> s_axis_tready && !m_axis_tvalid)
        else $error("Ports not idle during reset.");

endmodule

bind utf8_text_detector utd_checker u_utd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
